// ----- hdl/gexp_pkg.sv -----
// Shared types, field widths and codes for the greedy expansion unit.
`default_nettype none

package gexp_pkg;

    localparam int DEF_POSITIONS  = 32;
    localparam int DEF_STATES     = 16;
    localparam int DEF_MAX_DIGITS = 16;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 31;
    localparam int SLOT_W   = 5;
    localparam int DIGIT_W  = 4;
    localparam int STATE_W  = 4;
    localparam int LABEL_W  = 8;
    localparam int POS_W    = 5;

    localparam int ALPHA_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 5'd2;
    localparam logic [STATE_W-1:0] START_RESET = 4'd0;
    localparam logic [LABEL_W-1:0] LABEL_X     = 8'd88;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START    = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_WEIGHT = 2'd0,
        ACT_LOAD_TRANS  = 2'd1,
        ACT_LOAD_LABEL  = 2'd2,
        ACT_EXPAND      = 2'd3
    } action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        logic [SLOT_W-1:0]   slot;
        logic [DIGIT_W-1:0]  digit_in;
        logic [STATE_W-1:0]  target_state;
        logic [LABEL_W-1:0]  label_in;
    } in_item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit_out;
        logic [POS_W-1:0]   position;
        logic               last;
        logic [LABEL_W-1:0] final_label;
        logic               unrepresented;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic pos_inc;
        logic pos_dec;
        logic mul;
        logic cap;
        logic div_init;
        logic div_step;
        logic set_over;
        logic trn;
        logic emit;
        logic emit_final;
    } dp_cmd_t;

    typedef struct packed {
        logic expand;
        logic prod_le_rem;
        logic pos_zero;
        logic pos_top;
        logic bit_zero;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/gexp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gexp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/gexp_ctrl.sv -----
// Sequencer for weight search, digit selection, automaton step and result issue.
`default_nettype none

module gexp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  gexp_pkg::dp_stat_t stat,
    output gexp_pkg::dp_cmd_t  cmd
);
    import gexp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWAIT,
        ST_SMUL,
        ST_SCMP,
        ST_WWAIT,
        ST_WMUL,
        ST_WCMP,
        ST_DIV,
        ST_STEP,
        ST_TRN,
        ST_LWAIT,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = req_valid;
                if (req_valid && stat.expand)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT:
            begin
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                // first position whose top multiple exceeds the number starts the walk
                if (!stat.prod_le_rem)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
                else if (stat.pos_top)
                begin
                    cmd.set_over = 1'b1;
                    cmd.cap      = 1'b1;
                    state_next   = ST_STEP;
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = ST_SWAIT;
                end
            end
            ST_WWAIT:
            begin
                state_next = ST_WMUL;
            end
            ST_WMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_WCMP;
            end
            ST_WCMP:
            begin
                if (stat.prod_le_rem)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_STEP;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.bit_zero)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                // position zero goes out later together with the label
                if (stat.pos_zero)
                begin
                    state_next = ST_TRN;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_TRN;
                end
            end
            ST_TRN:
            begin
                cmd.trn = 1'b1;
                if (stat.pos_zero)
                begin
                    state_next = ST_LWAIT;
                end
                else
                begin
                    cmd.pos_dec = 1'b1;
                    state_next  = ST_WWAIT;
                end
            end
            ST_LWAIT:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gexp_dp.sv -----
// Datapath: tables, configuration, remainder, digit divider, automaton state, result register.
`default_nettype none

module gexp_dp #(
    parameter int POSITIONS  = gexp_pkg::DEF_POSITIONS,
    parameter int STATES     = gexp_pkg::DEF_STATES,
    parameter int MAX_DIGITS = gexp_pkg::DEF_MAX_DIGITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gexp_pkg::in_item_t                  req,
    input  logic                                cfg_we,
    input  logic [gexp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gexp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  gexp_pkg::dp_cmd_t                   cmd,
    output gexp_pkg::dp_stat_t                  stat,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output gexp_pkg::out_item_t                 rsp
);
    import gexp_pkg::*;

    localparam int PW = $clog2(POSITIONS);
    localparam int SW = (STATES > 1) ? $clog2(STATES) : 1;
    localparam int DW = $clog2(MAX_DIGITS);
    localparam int BW = (DW > 1) ? $clog2(DW) : 1;
    localparam int WX = VALUE_W + DW;

    // configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [STATE_W-1:0] start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            start_reg <= START_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALPHABET: alpha_reg <= ALPHA_W'(cfg_data);
                REG_START:    start_reg <= STATE_W'(cfg_data);
                default:      ;
            endcase
        end
    end

    // largest digit, alphabet size clamped into its legal range
    logic [DW-1:0] km1;

    always_comb
    begin
        if (alpha_reg < ALPHA_W'(2))
        begin
            km1 = DW'(1);
        end
        else if (int'(alpha_reg) > MAX_DIGITS)
        begin
            km1 = DW'(MAX_DIGITS - 1);
        end
        else
        begin
            km1 = DW'(alpha_reg - ALPHA_W'(1));
        end
    end

    // table writes from load requests
    logic load_w;
    logic load_t;
    logic load_l;

    assign load_w = cmd.accept && (req.action == ACT_LOAD_WEIGHT) && (int'(req.slot) < POSITIONS);
    assign load_t = cmd.accept && (req.action == ACT_LOAD_TRANS) && (int'(req.slot) < STATES)
                    && (int'(req.digit_in) < MAX_DIGITS);
    assign load_l = cmd.accept && (req.action == ACT_LOAD_LABEL) && (int'(req.slot) < STATES);

    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [WX-1:0]      prod_reg;
    logic [WX-1:0]      prod_next;
    logic [DW-1:0]      q_reg;
    logic [DW-1:0]      q_next;
    logic [BW-1:0]      bit_reg;
    logic [BW-1:0]      bit_next;
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    logic [STATE_W-1:0] st_reg;
    logic [STATE_W-1:0] st_next;
    logic               over_reg;
    logic               over_next;

    logic [VALUE_W-1:0] w_rd;
    logic [STATE_W-1:0] trans_rd;
    logic [LABEL_W-1:0] label_rd;
    logic               st_ok;

    assign st_ok = (int'(st_reg) < STATES);

    gexp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (2 ** PW)
    ) u_weight_ram (
        .clk   (clk),
        .we    (load_w),
        .waddr (PW'(req.slot)),
        .wdata (req.value),
        .raddr (pos_reg),
        .rdata (w_rd)
    );

    gexp_ram #(
        .WIDTH (STATE_W),
        .DEPTH (2 ** (SW + DW))
    ) u_trans_ram (
        .clk   (clk),
        .we    (load_t),
        .waddr ({SW'(req.slot), DW'(req.digit_in)}),
        .wdata (req.target_state),
        .raddr ({(st_ok ? SW'(st_reg) : SW'(0)), q_reg}),
        .rdata (trans_rd)
    );

    gexp_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (2 ** SW)
    ) u_label_ram (
        .clk   (clk),
        .we    (load_l),
        .waddr (SW'(req.slot)),
        .wdata (req.label_in),
        .raddr (SW'(st_reg)),
        .rdata (label_rd)
    );

    logic [WX-1:0] rem_ext;
    logic [WX-1:0] cand;

    assign rem_ext = WX'(rem_reg);
    assign cand    = WX'(w_rd) << bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        prod_next = prod_reg;
        q_next    = q_reg;
        bit_next  = bit_reg;
        pos_next  = pos_reg;
        st_next   = st_reg;
        over_next = over_reg;

        if (cmd.start)
        begin
            rem_next  = req.value;
            st_next   = start_reg;
            pos_next  = '0;
            over_next = 1'b0;
        end
        if (cmd.pos_inc)
        begin
            pos_next = pos_reg + PW'(1);
        end
        if (cmd.pos_dec)
        begin
            pos_next = pos_reg - PW'(1);
        end
        if (cmd.mul)
        begin
            prod_next = WX'(w_rd) * WX'(km1);
        end
        if (cmd.set_over)
        begin
            over_next = 1'b1;
        end
        // top digit fits: take it whole
        if (cmd.cap)
        begin
            rem_next = VALUE_W'(rem_ext - prod_reg);
            q_next   = km1;
        end
        if (cmd.div_init)
        begin
            q_next   = '0;
            bit_next = BW'(DW - 1);
        end
        // restoring division, one digit bit per cycle
        if (cmd.div_step)
        begin
            if (rem_ext >= cand)
            begin
                rem_next        = VALUE_W'(rem_ext - cand);
                q_next[bit_reg] = 1'b1;
            end
            bit_next = bit_reg - BW'(1);
        end
        if (cmd.trn)
        begin
            st_next = trans_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        bit_reg  <= bit_next;
        pos_reg  <= pos_next;
        st_reg   <= st_next;
        over_reg <= over_next;
    end

    // result register
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    out_item_t rsp_reg;
    out_item_t rsp_next;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.emit || cmd.emit_final)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.digit_out     = DIGIT_W'(q_reg);
            rsp_next.position      = POS_W'(pos_reg);
            rsp_next.last          = cmd.emit_final;
            rsp_next.final_label   = '0;
            rsp_next.unrepresented = 1'b0;
            if (cmd.emit_final)
            begin
                if (rem_reg != '0)
                begin
                    rsp_next.final_label = LABEL_X;
                end
                else if (st_ok)
                begin
                    rsp_next.final_label = label_rd;
                end
                rsp_next.unrepresented = (rem_reg != '0) || over_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign stat.expand      = (req.action == ACT_EXPAND);
    assign stat.prod_le_rem = (prod_reg <= rem_ext);
    assign stat.pos_zero    = (pos_reg == '0);
    assign stat.pos_top     = (pos_reg == PW'(POSITIONS - 1));
    assign stat.bit_zero    = (bit_reg == '0);
    assign stat.out_free    = !rsp_valid_reg || rsp_ready;

endmodule

`default_nettype wire

// ----- hdl/greedy_expansion_with_automaton_unit.sv -----
// Top level of the greedy digit expansion unit with automaton labeling.
// Requests arrive on req (valid/ready). Load requests (weight, transition, label)
// are taken while idle and give no result. An expand request yields one result
// per position, from the start position down to zero, on rsp (valid/ready); the
// result at position zero has last set and carries the final label and flag.
// Configuration (alphabet size, start state) is written through cfg_we/cfg_index/
// cfg_data, by the user only while no expansion runs; the block does not enforce it.
// Steps of one expansion: the search tries positions upward from zero, each with a
// weight RAM read, a multiply by the top digit and a compare, up to the first
// position whose top multiple exceeds the number; that start position takes its
// digit from the digit divider. Each position below it takes a weight read,
// multiply and compare, plus the divider when its digit is below the top digit;
// every position ends with the automaton step, and the final label read and issue
// close the expansion. One expansion is worked at a time; req_ready is low until
// the last result is loaded into the output register.
// A stalled receiver holds the walk at the next result until the output register
// frees up. Reset clears the controller, the result valid and the configuration
// (alphabet size 2, start state 0); table contents stay undefined until loaded.
`default_nettype none

module greedy_expansion_with_automaton_unit #(
    parameter int POSITIONS  = gexp_pkg::DEF_POSITIONS,
    parameter int STATES     = gexp_pkg::DEF_STATES,
    parameter int MAX_DIGITS = gexp_pkg::DEF_MAX_DIGITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  gexp_pkg::in_item_t               req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output gexp_pkg::out_item_t              rsp,
    input  logic                             cfg_we,
    input  logic [gexp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gexp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gexp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    gexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gexp_dp #(
        .POSITIONS  (POSITIONS),
        .STATES     (STATES),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // never overwrite a result that the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.emit_final) |-> stat.out_free)
        else $error("result register overwritten");

    // the final result ends the expansion
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_final |=> req_ready)
        else $error("not idle after final result");

    // one datapath arithmetic operation at a time
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul, cmd.cap, cmd.div_init, cmd.div_step}))
        else $error("conflicting datapath commands");

    // a new expansion starts only on an accepted request
    a_start_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (req_valid && req_ready))
        else $error("expansion started without a request");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the greedy expansion unit with its digit automaton.
module tb_top;

    import gexp_pkg::*;

    localparam int POSITIONS      = DEF_POSITIONS;
    localparam int STATES         = DEF_STATES;
    localparam int MAX_DIGITS     = DEF_MAX_DIGITS;
    localparam int DRAIN_CYCLES   = 16;
    // longest quiet stretch: full search plus one divider walk step and a receiver stall
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 40;
    // the automaton is kept to these two states so that every reachable entry is loaded
    localparam int ST_LO          = 0;
    localparam int ST_HI          = STATES - 1;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_item_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // copy of the unit's tables and settings
    logic [VALUE_W-1:0] weight_mem [POSITIONS];
    logic [STATE_W-1:0] trans_mem  [STATES][MAX_DIGITS];
    logic [LABEL_W-1:0] label_mem  [STATES];
    logic [ALPHA_W-1:0] alphabet_q;
    logic [STATE_W-1:0] start_q;

    out_item_t pending_digits [$];

    bit stalls_on;
    int err_count;
    int n_expand;
    int n_load;
    int n_result;
    int n_settings;

    greedy_expansion_with_automaton_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int effective_radix();
        if (alphabet_q < 2)
            return 2;
        else if (alphabet_q > MAX_DIGITS)
            return MAX_DIGITS;
        return int'(alphabet_q);
    endfunction

    // Update the tables for a load, or queue the digits an expansion must produce.
    function automatic void digits_for_request(in_item_t it);
        logic [63:0] rem;
        logic [STATE_W-1:0] st;
        logic [DIGIT_W-1:0] d;
        out_item_t r;
        int k;
        int top;
        bit over;
        k = effective_radix();
        case (it.action)
            ACT_LOAD_WEIGHT:
            begin
                n_load++;
                if (it.slot < POSITIONS)
                    weight_mem[it.slot] = it.value;
            end
            ACT_LOAD_TRANS:
            begin
                n_load++;
                if (it.slot < STATES && it.digit_in < MAX_DIGITS)
                    trans_mem[it.slot][it.digit_in] = it.target_state;
            end
            ACT_LOAD_LABEL:
            begin
                n_load++;
                if (it.slot < STATES)
                    label_mem[it.slot] = it.label_in;
            end
            default:
            begin
                n_expand++;
                rem = 64'(it.value);
                st = start_q;
                top = POSITIONS - 1;
                over = 1'b1;
                for (int p = 0; p < POSITIONS; p++)
                    if (over && 64'(weight_mem[p]) * 64'(k - 1) > rem)
                    begin
                        top = p;
                        over = 1'b0;
                    end
                for (int p = top; p >= 0; p--)
                begin
                    d = '0;
                    for (int j = k - 1; j > 0; j--)
                        if (d == 0 && 64'(j) * 64'(weight_mem[p]) <= rem)
                            d = j[DIGIT_W-1:0];
                    rem = rem - 64'(d) * 64'(weight_mem[p]);
                    st = trans_mem[st][d];
                    r = '0;
                    r.digit_out = d;
                    r.position = p[POS_W-1:0];
                    r.last = (p == 0);
                    if (p == 0)
                    begin
                        r.final_label = (rem != 0) ? LABEL_X : label_mem[st];
                        r.unrepresented = (rem != 0) || over;
                    end
                    pending_digits.push_back(r);
                end
            end
        endcase
    endfunction

    function automatic in_item_t rand_item(action_t act);
        logic [63:0] bits;
        in_item_t it;
        bits = {$urandom(), $urandom()};
        it = bits[$bits(in_item_t)-1:0];
        it.action = act;
        return it;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [31:0] raw;
        raw = $urandom() >> $urandom_range(0, 31);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return raw[VALUE_W-1:0];
        endcase
    endfunction

    function automatic int rand_target();
        return ($urandom_range(0, 1) == 0) ? ST_LO : ST_HI;
    endfunction

    // upper data bit lies outside the state field and is dropped by the unit
    function automatic logic [CFG_DATA_W-1:0] rand_start();
        logic [CFG_DATA_W-1:0] s;
        s = CFG_DATA_W'(rand_target());
        s[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // Hold the request until accepted; predict at the accepting edge.
    task automatic send_request(in_item_t it);
        int gap;
        gap = 0;
        if (stalls_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= it;
        do
            @(posedge clk);
        while (!req_ready);
        digits_for_request(it);
    endtask

    task automatic send_expand(logic [VALUE_W-1:0] value);
        in_item_t it;
        it = rand_item(ACT_EXPAND);
        it.value = value;
        send_request(it);
    endtask

    task automatic send_load(action_t act, int slot, logic [VALUE_W-1:0] value,
                             int digit, int target, int label);
        in_item_t it;
        it = rand_item(act);
        it.slot = slot[SLOT_W-1:0];
        it.value = value;
        it.digit_in = digit[DIGIT_W-1:0];
        it.target_state = target[STATE_W-1:0];
        it.label_in = label[LABEL_W-1:0];
        send_request(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(logic [ALPHA_W-1:0] alpha, logic [CFG_DATA_W-1:0] start_data);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_ALPHABET;
        cfg_data <= alpha;
        @(negedge clk);
        cfg_index <= REG_START;
        cfg_data <= start_data;
        @(negedge clk);
        cfg_we <= 1'b0;
        alphabet_q = alpha;
        start_q = start_data[STATE_W-1:0];
        n_settings++;
    endtask

    // Fill every weight position; the scheme picks the shape of the series.
    task automatic load_weight_set(int scheme);
        logic [63:0] w;
        logic [63:0] prev;
        logic [63:0] sum;
        int k;
        k = effective_radix();
        w = 64'd1;
        prev = 64'd1;
        for (int p = 0; p < POSITIONS; p++)
        begin
            case (scheme)
                0:
                    if (p > 0)
                        w = w * 64'(k);
                1:
                    if (p > 0)
                    begin
                        sum = w + prev;
                        prev = w;
                        w = sum;
                    end
                2:
                    if (p == 0)
                        w = 64'($urandom_range(1, 3));
                    else
                        w = w + 64'($urandom_range(1, 32'(w)));
                default:
                begin
                    w = 64'($urandom() >> $urandom_range(0, 31));
                    if ($urandom_range(0, 5) == 0)
                        w = 64'd0;
                end
            endcase
            if (w > 64'h7FFF_FFFF)
                w = 64'h7FFF_FFFF;
            send_load(ACT_LOAD_WEIGHT, p, w[VALUE_W-1:0], 0, 0, 0);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic test_table_fill();
        send_load(ACT_LOAD_LABEL, ST_LO, rand_value(), 0, 0, $urandom_range(0, 255));
        send_load(ACT_LOAD_LABEL, ST_HI, rand_value(), 0, 0, $urandom_range(0, 255));
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            send_load(ACT_LOAD_TRANS, ST_LO, rand_value(), d, rand_target(), 0);
            send_load(ACT_LOAD_TRANS, ST_HI, rand_value(), d, rand_target(), 0);
        end
        load_weight_set(0);
    endtask

    task automatic test_directed_expansions();
        send_expand('0);
        send_expand(31'd1);
        send_expand(31'd2);
        send_expand('1);            // top weight does not exceed it: no start position
        send_expand(31'h4000_0000);
        send_expand(31'h2AAA_AAAA);
    endtask

    task automatic test_load_edges();
        send_load(ACT_LOAD_LABEL, 0, '0, 0, 0, 8'hFF);
        send_load(ACT_LOAD_LABEL, STATES - 1, '1, 0, 0, 8'h00);
        send_load(ACT_LOAD_TRANS, 0, '0, 0, STATES - 1, 0);
        send_load(ACT_LOAD_TRANS, STATES - 1, '1, MAX_DIGITS - 1, 0, 0);
        // slots past the state count must be dropped
        send_load(ACT_LOAD_TRANS, 31, '1, MAX_DIGITS - 1, 15, 8'hFF);
        send_load(ACT_LOAD_LABEL, 16, '0, 0, 15, 8'hAA);
        // zero weight in the middle of the series
        send_load(ACT_LOAD_WEIGHT, 3, '0, 0, 0, 0);
        send_expand(31'd100);
        send_load(ACT_LOAD_WEIGHT, 3, 31'd8, 0, 0, 0);
    endtask

    task automatic test_setting_extremes();
        write_settings(5'd0, 5'd15);
        send_expand(31'd37);
        write_settings(5'd31, 5'h10);
        send_expand('1);
        send_expand(31'h0001_2345);
        write_settings(5'd1, 5'h1F);
        send_expand(31'd5);
        write_settings(5'd17, 5'h00);
        send_expand('1);
    endtask

    task automatic test_random_phase(logic [ALPHA_W-1:0] alpha, int n_items);
        int pick;
        write_settings(alpha, rand_start());
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_expand(rand_value());
            else if (pick < 82)
                send_load(ACT_LOAD_WEIGHT, $urandom_range(0, 31), rand_value(), 0, 0, 0);
            else if (pick < 92)
                send_load(ACT_LOAD_TRANS, $urandom_range(0, 31), rand_value(),
                          $urandom_range(0, 15), rand_target(), $urandom_range(0, 255));
            else
                send_load(ACT_LOAD_LABEL, $urandom_range(0, 31), rand_value(),
                          $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255));
        end
    endtask

    task automatic test_no_stalls(int n_items);
        wait_idle();
        stalls_on = 1'b0;
        test_random_phase(5'($urandom_range(2, 16)), n_items);
    endtask

    // receiver side: random stall bursts
    initial
    begin
        int stall;
        stall = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 15);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // result checker
    initial
    begin
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                n_result++;
                if (pending_digits.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $error("result at position %0d with no expansion pending", rsp.position);
                end
                else
                begin
                    want = pending_digits.pop_front();
                    check_field("digit_out", want.digit_out, rsp.digit_out);
                    check_field("position", want.position, rsp.position);
                    check_field("last", want.last, rsp.last);
                    check_field("final_label", want.final_label, rsp.final_label);
                    check_field("unrepresented", want.unrepresented, rsp.unrepresented);
                end
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        alphabet_q = ALPHA_RESET;
        start_q = START_RESET;
        stalls_on = 1'b1;
        err_count = 0;
        n_expand = 0;
        n_load = 0;
        n_result = 0;
        n_settings = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_settings(ALPHA_RESET, 5'(START_RESET));
        test_table_fill();
        test_directed_expansions();
        test_load_edges();
        test_setting_extremes();
        test_random_phase(5'd16, 8);
        test_random_phase(5'd0, 8);
        test_random_phase(5'd31, 8);
        test_random_phase(5'($urandom_range(3, 15)), 8);
        test_random_phase(5'($urandom_range(0, 31)), 6);
        test_no_stalls(8);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d expansions with %0d digits checked, and %0d table loads,",
                 n_expand, n_result, n_load);
        $display("over %0d register settings, with and without handshake stalls.", n_settings);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/gexp_pkg.sv
hdl/gexp_ram.sv
hdl/gexp_ctrl.sv
hdl/gexp_dp.sv
hdl/greedy_expansion_with_automaton_unit.sv
verif/tb_top.sv
